@@ rtl/lnp_pkg.sv @@
// Package for the linked-list node pool: status and command codes, the
// sequencer's control word and its microcode table. No dependencies.
package lnp_pkg;

	localparam int ITEM_VALUE_W = 32;
	localparam int STATUS_W     = 2;
	localparam int NODE_INDEX_W = 8;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_REMOVED   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	// microcode addresses
	typedef enum logic [3:0] {
		P_IDLE,
		P_DISPATCH,
		P_INS_FREE,
		P_INS_POP,
		P_INS_NEW,
		P_INS_WRITE,
		P_FULL,
		P_WALK,
		P_UNLINK,
		P_RELEASE,
		P_MISS,
		P_EMIT
	} step_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_POP_FREE,
		OP_POP_TOP,
		OP_WRITE_NEW,
		OP_ADVANCE,
		OP_UNLINK,
		OP_RELEASE,
		OP_MISS,
		OP_FULL,
		OP_EMIT
	} op_t;

	// pool read address source
	typedef enum logic [1:0] {
		RD_NONE,
		RD_FREE,
		RD_CUR,
		RD_LINK
	} rd_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ACCEPT,
		C_CMD_REMOVE,
		C_FREE_VALID,
		C_TOP_AVAIL,
		C_WALK_END,
		C_MATCH,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		rd_t   rd;
		logic  fall_only;  // op and read only when no jump is taken
		cond_t cond_a;
		step_t tgt_a;
		cond_t cond_b;
		step_t tgt_b;
		step_t tgt_else;
	} ctrl_t;

	typedef struct packed {
		logic accept;
		logic cmd_remove;
		logic free_valid;
		logic top_avail;
		logic walk_end;
		logic match;
		logic out_free;
	} cond_flags_t;

	typedef struct packed {
		ctrl_t word;
		logic  fell;
		logic  idle;
	} seq_out_t;

	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		unique case (s)
			P_IDLE:      w = '{OP_LATCH, RD_NONE, 1'b0,
			                   C_ACCEPT, P_DISPATCH, C_NEVER, P_IDLE, P_IDLE};
			P_DISPATCH:  w = '{OP_NONE, RD_CUR, 1'b0,
			                   C_CMD_REMOVE, P_WALK, C_NEVER, P_IDLE, P_INS_FREE};
			P_INS_FREE:  w = '{OP_NONE, RD_FREE, 1'b0,
			                   C_FREE_VALID, P_INS_POP, C_TOP_AVAIL, P_INS_NEW, P_FULL};
			P_INS_POP:   w = '{OP_POP_FREE, RD_NONE, 1'b0,
			                   C_NEVER, P_IDLE, C_NEVER, P_IDLE, P_INS_WRITE};
			P_INS_NEW:   w = '{OP_POP_TOP, RD_NONE, 1'b0,
			                   C_NEVER, P_IDLE, C_NEVER, P_IDLE, P_INS_WRITE};
			P_INS_WRITE: w = '{OP_WRITE_NEW, RD_NONE, 1'b0,
			                   C_NEVER, P_IDLE, C_NEVER, P_IDLE, P_EMIT};
			P_FULL:      w = '{OP_FULL, RD_NONE, 1'b0,
			                   C_NEVER, P_IDLE, C_NEVER, P_IDLE, P_EMIT};
			P_WALK:      w = '{OP_ADVANCE, RD_LINK, 1'b1,
			                   C_WALK_END, P_MISS, C_MATCH, P_UNLINK, P_WALK};
			P_UNLINK:    w = '{OP_UNLINK, RD_NONE, 1'b0,
			                   C_NEVER, P_IDLE, C_NEVER, P_IDLE, P_RELEASE};
			P_RELEASE:   w = '{OP_RELEASE, RD_NONE, 1'b0,
			                   C_NEVER, P_IDLE, C_NEVER, P_IDLE, P_EMIT};
			P_MISS:      w = '{OP_MISS, RD_NONE, 1'b0,
			                   C_NEVER, P_IDLE, C_NEVER, P_IDLE, P_EMIT};
			P_EMIT:      w = '{OP_EMIT, RD_NONE, 1'b0,
			                   C_OUT_FREE, P_IDLE, C_NEVER, P_IDLE, P_EMIT};
			default:     w = '{OP_NONE, RD_NONE, 1'b0,
			                   C_NEVER, P_IDLE, C_NEVER, P_IDLE, P_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic cond_hit(cond_t c, cond_flags_t f);
		logic h;
		unique case (c)
			C_NEVER:      h = 1'b0;
			C_ACCEPT:     h = f.accept;
			C_CMD_REMOVE: h = f.cmd_remove;
			C_FREE_VALID: h = f.free_valid;
			C_TOP_AVAIL:  h = f.top_avail;
			C_WALK_END:   h = f.walk_end;
			C_MATCH:      h = f.match;
			C_OUT_FREE:   h = f.out_free;
			default:      h = 1'b0;
		endcase
		return h;
	endfunction

endpackage

@@ rtl/lnp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lnp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lnp_seq.sv @@
// Microcode sequencer: step counter, control-word table lookup and
// two-way conditional jumps. Depends on lnp_pkg.
module lnp_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  lnp_pkg::cond_flags_t flags,
	output lnp_pkg::seq_out_t   seq
);
	import lnp_pkg::*;

	step_t step_q;
	step_t step_d;
	ctrl_t word;
	logic  hit_a;
	logic  hit_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= P_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		word  = ucode(step_q);
		hit_a = cond_hit(word.cond_a, flags);
		hit_b = cond_hit(word.cond_b, flags);
		if (hit_a) begin
			step_d = word.tgt_a;
		end else if (hit_b) begin
			step_d = word.tgt_b;
		end else begin
			step_d = word.tgt_else;
		end
		seq.word = word;
		seq.fell = !hit_a && !hit_b;
		seq.idle = (step_q == P_IDLE);
	end

endmodule

@@ rtl/linked_list_node_pool.sv @@
// Top level of the linked-list node pool: datapath, pool memories and
// the microcoded sequencer. Depends on lnp_pkg, lnp_ram and lnp_seq.
//
//   channel | signals                         | beat carries
//   --------+---------------------------------+------------------------------
//   input   | in_valid, in_stall              | cmd, item_value
//   output  | out_valid, out_stall            | status, node_index
//
// Insert pops the free list, or else the never-used pointer, writes the node and emits;
// a pool with neither reports full. Remove walks at most POOL_NODES nodes from the head;
// the walk is paced by the single read port of the link/value memories.
// Reset nulls head and free list and zeroes the never-used pointer; no clearing
// pass, pool entries are only read after being written.
// A new beat is taken while an earlier result still waits on out_stall; the
// sequencer holds in its emit step until the output register frees up.
module linked_list_node_pool #(
	parameter int POOL_NODES = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  cmd,
	input  logic [lnp_pkg::ITEM_VALUE_W-1:0]     item_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [lnp_pkg::STATUS_W-1:0]         status,
	output logic [lnp_pkg::NODE_INDEX_W-1:0]     node_index
);
	import lnp_pkg::*;

	localparam int IDX_W = $clog2(POOL_NODES);
	localparam int PTR_W = IDX_W + 1;          // room for the null pointer
	localparam int VW    = (VALUE_BITS < ITEM_VALUE_W) ? VALUE_BITS : ITEM_VALUE_W;
	localparam int OW    = (IDX_W < NODE_INDEX_W) ? IDX_W : NODE_INDEX_W;
	localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(POOL_NODES);

	// sequencer interface
	cond_flags_t flags;
	seq_out_t    seq;
	ctrl_t       ctrl;
	logic        go;

	// list registers
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] free_q;
	logic [PTR_W-1:0] top_q;
	logic [PTR_W-1:0] cur_q;
	logic [PTR_W-1:0] prev_q;
	logic [PTR_W-1:0] steps_q;
	cmd_t             cmd_q;
	logic [VW-1:0]    val_q;
	status_t          res_status_q;
	logic [IDX_W-1:0] res_idx_q;

	// output register
	logic                    out_valid_q;
	status_t                 status_q;
	logic [NODE_INDEX_W-1:0] node_index_q;
	logic                    emit_load;

	// pool memory ports
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [PTR_W-1:0] link_rd;
	logic [VW-1:0]    val_rd;
	logic             link_we;
	logic [IDX_W-1:0] link_waddr;
	logic [PTR_W-1:0] link_wdata;
	logic             val_we;
	logic             prev_valid;

	lnp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.seq    (seq)
	);

	assign ctrl = seq.word;
	// the walk step only advances when it neither finishes nor matches
	assign go   = !ctrl.fall_only || seq.fell;

	assign prev_valid = (prev_q < PTR_NULL);

	always_comb begin
		flags.accept     = in_valid && !in_stall;
		flags.cmd_remove = (cmd_q == CMD_REMOVE);
		flags.free_valid = (free_q < PTR_NULL);
		flags.top_avail  = (top_q < PTR_NULL);
		flags.walk_end   = !(cur_q < PTR_NULL) || (steps_q >= PTR_NULL);
		flags.match      = (val_rd == val_q);
		flags.out_free   = !out_valid_q || !out_stall;
	end

	// read address; a null pointer just reads a don't-care entry
	always_comb begin
		rd_en = (ctrl.rd != RD_NONE) && go;
		unique case (ctrl.rd)
			RD_NONE: rd_addr = '0;
			RD_FREE: rd_addr = free_q[IDX_W-1:0];
			RD_CUR:  rd_addr = cur_q[IDX_W-1:0];
			RD_LINK: rd_addr = link_rd[IDX_W-1:0];
			default: rd_addr = '0;
		endcase
	end

	// memory writes
	always_comb begin
		link_we    = 1'b0;
		link_waddr = res_idx_q;
		link_wdata = head_q;
		val_we     = 1'b0;
		if (go) begin
			unique case (ctrl.op)
				OP_WRITE_NEW: begin
					link_we = 1'b1;
					val_we  = 1'b1;
				end
				OP_UNLINK: begin
					link_we    = prev_valid;
					link_waddr = prev_q[IDX_W-1:0];
					link_wdata = link_rd;
				end
				OP_RELEASE: begin
					link_we    = 1'b1;
					link_waddr = cur_q[IDX_W-1:0];
					link_wdata = free_q;
				end
				default: begin
				end
			endcase
		end
	end

	lnp_ram #(
		.WIDTH (PTR_W),
		.DEPTH (POOL_NODES)
	) u_links (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	lnp_ram #(
		.WIDTH (VW),
		.DEPTH (POOL_NODES)
	) u_values (
		.clk   (clk),
		.we    (val_we),
		.waddr (res_idx_q),
		.wdata (val_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (val_rd)
	);

	assign emit_load = go && (ctrl.op == OP_EMIT) && flags.out_free;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= PTR_NULL;
			free_q      <= PTR_NULL;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				unique case (ctrl.op)
					OP_POP_FREE:  free_q <= link_rd;
					OP_POP_TOP:   top_q  <= top_q + 1'b1;
					OP_WRITE_NEW: head_q <= PTR_W'(res_idx_q);
					OP_UNLINK: begin
						if (!prev_valid) begin
							head_q <= link_rd;
						end
					end
					OP_RELEASE:   free_q <= cur_q;
					default: begin
					end
				endcase
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (go) begin
			unique case (ctrl.op)
				OP_LATCH: begin
					cmd_q   <= cmd_t'(cmd);
					val_q   <= item_value[VW-1:0];
					cur_q   <= head_q;
					prev_q  <= PTR_NULL;
					steps_q <= '0;
				end
				OP_POP_FREE: res_idx_q <= free_q[IDX_W-1:0];
				OP_POP_TOP:  res_idx_q <= top_q[IDX_W-1:0];
				OP_WRITE_NEW: res_status_q <= ST_INSERTED;
				OP_ADVANCE: begin
					prev_q  <= cur_q;
					cur_q   <= link_rd;
					steps_q <= steps_q + 1'b1;
				end
				OP_RELEASE: begin
					res_status_q <= ST_REMOVED;
					res_idx_q    <= cur_q[IDX_W-1:0];
				end
				OP_MISS: begin
					res_status_q <= ST_NOT_FOUND;
					res_idx_q    <= '0;
				end
				OP_FULL: begin
					res_status_q <= ST_FULL;
					res_idx_q    <= '0;
				end
				default: begin
				end
			endcase
		end
		if (emit_load) begin
			status_q     <= res_status_q;
			node_index_q <= NODE_INDEX_W'(res_idx_q[OW-1:0]);
		end
	end

	assign in_stall   = !seq.idle;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign node_index = node_index_q;

endmodule

@@ rtl/lnp_checker.sv @@
// Port-level checks for the linked-list node pool, bound to the top level.
// Depends on lnp_pkg and linked_list_node_pool.
module lnp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [lnp_pkg::STATUS_W-1:0]     status,
	input logic [lnp_pkg::NODE_INDEX_W-1:0] node_index
);
	import lnp_pkg::*;

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(node_index))
		else $error("result beat changed while stalled");

	// one command at a time: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a command is in progress");

	// miss and full carry index zero
	a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_FOUND || status == ST_FULL) |-> node_index == '0)
		else $error("nonzero index on not-found or full");

	// no result can be ready the cycle after a beat is taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind linked_list_node_pool lnp_checker u_lnp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.node_index (node_index)
);
